@@ hw/rtl/ssrm_pkg.sv @@
// Shared types and constants for the step sequencer with random modes.
package ssrm_pkg;

  localparam int unsigned ValW     = 16;
  localparam int unsigned FracBits = 14;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned SumW     = 19;

  localparam logic signed [ValW-1:0]  ScaleReset  = 16'sd16384;
  localparam logic signed [ValW-1:0]  OffsetReset = 16'sd0;
  localparam logic signed [ProdW-1:0] RoundHalf   = 32'sd8192;
  localparam logic signed [SumW-1:0]  OutMax      = 19'sd32767;
  localparam logic signed [SumW-1:0]  OutMin      = -19'sd32767;

  // Configuration register map
  typedef enum logic [0:0] {
    CfgScale  = 1'b0,
    CfgOffset = 1'b1
  } cfg_reg_e;

  // Gate history bit positions
  localparam int unsigned GateClk  = 0;
  localparam int unsigned GateRev  = 1;
  localparam int unsigned GateRnd  = 2;
  localparam int unsigned GateHold = 3;
  localparam int unsigned GateRst  = 4;
  localparam int unsigned GateW    = 5;

  // Indicator lamps for one result word
  typedef struct packed {
    logic reverse;
    logic random;
    logic forward;
  } lamps_t;

endpackage

@@ hw/rtl/ssrm_scale.sv @@
// Output gain and offset stage: round(sample * scale / 2^14) + offset, saturated.
module ssrm_scale
  import ssrm_pkg::*;
(
  input  logic signed [ValW-1:0] sample_i,
  input  logic signed [ValW-1:0] scale_i,
  input  logic signed [ValW-1:0] offset_i,
  output logic signed [ValW-1:0] result_o
);

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] rounded;
  logic signed [SumW-1:0]  shifted;
  logic signed [SumW-1:0]  sum;

  // Multiply, round half up, floor shift back to integer
  assign prod    = ProdW'(sample_i) * ProdW'(scale_i);
  assign rounded = prod + RoundHalf;
  assign shifted = SumW'(rounded >>> FracBits);
  assign sum     = shifted + SumW'(offset_i);

  // Clamp to +/-10 V
  always_comb begin
    if (sum > OutMax) begin
      result_o = ValW'(OutMax);
    end else if (sum < OutMin) begin
      result_o = ValW'(OutMin);
    end else begin
      result_o = ValW'(sum);
    end
  end

endmodule

@@ hw/rtl/step_sequencer_random_modes.sv @@
// Step sequencer: forward, reverse, random walk and random hop, with scaled output.
// An accepted input word passes through the input register, then the mode update
// and scaling into the result register.
// Throughput: one word per cycle; the pipeline only stalls when the result
// register is full and the downstream side stalls.
// Reset: asynchronous, clears all sequencer state; scale returns to 1.0, offset to 0.
module step_sequencer_random_modes
  import ssrm_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [0:0]             cfg_index_i,
  input  logic [ValW-1:0]        cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   clock_plugged_i,
  input  logic                   clock_level_i,
  input  logic                   reverse_level_i,
  input  logic                   random_level_i,
  input  logic                   hold_level_i,
  input  logic                   reset_level_i,
  input  logic [15:0]            step_buttons_i,
  input  logic signed [ValW-1:0] step_value_i,
  input  logic                   random_bit_i,
  input  logic [3:0]             random_hop_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             position_o,
  output logic [3:0]             reset_position_o,
  output logic signed [ValW-1:0] out_value_o,
  output logic                   reverse_lamp_o,
  output logic                   random_lamp_o,
  output logic                   forward_lamp_o
);

  localparam int unsigned IdxW       = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned WrapW      = IdxW + 5;
  localparam int unsigned WrapRounds = 1 + 15 / STEPS;
  localparam int unsigned NumBtn     = (STEPS < 16) ? STEPS : 16;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(STEPS - 1);

  // (p + d) mod STEPS with p < STEPS, d < 16
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] p,
                                               input logic [3:0] d);
    logic [WrapW-1:0] s;
    s = WrapW'(p) + WrapW'(d);
    for (int r = 0; r < WrapRounds; r++) begin
      if (s >= WrapW'(STEPS)) begin
        s = s - WrapW'(STEPS);
      end
    end
    return s[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] wrap_dec(input logic [IdxW-1:0] p);
    return (p == '0) ? LastIdx : p - IdxW'(1);
  endfunction

  // ---------------- configuration registers ----------------
  logic signed [ValW-1:0] scale_q, offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleReset;
      offset_q <= OffsetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgScale:  scale_q  <= cfg_data_i;
        CfgOffset: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic in_valid_q;
  logic out_advance, in_advance;

  assign out_advance = !out_valid_o || !out_stall_i;
  assign in_advance  = !in_valid_q || out_advance;
  assign in_stall_o  = !in_advance;

  // ---------------- input register ----------------
  logic                   plugged_q, clk_lvl_q, rev_lvl_q, rnd_lvl_q, hold_lvl_q, rst_lvl_q;
  logic [15:0]            buttons_q;
  logic signed [ValW-1:0] sample_q;
  logic                   walk_up_q;
  logic [3:0]             hop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && in_valid_i) begin
      plugged_q  <= clock_plugged_i;
      clk_lvl_q  <= clock_level_i;
      rev_lvl_q  <= reverse_level_i;
      rnd_lvl_q  <= random_level_i;
      hold_lvl_q <= hold_level_i;
      rst_lvl_q  <= reset_level_i;
      buttons_q  <= step_buttons_i;
      sample_q   <= step_value_i;
      walk_up_q  <= random_bit_i;
      hop_q      <= random_hop_i;
    end
  end

  // ---------------- sequencer state ----------------
  logic [IdxW-1:0]  cur_q, cur_d, count_q, count_d, home_q, home_d;
  logic             held_q, held_d, random_q, random_d;
  logic             reversed_q, reversed_d, hopping_q, hopping_d;
  logic [GateW-1:0] gate_hist_q, gate_hist_d;
  logic [15:0]      btn_hist_q;
  logic             update;
  logic             running;
  logic [GateW-1:0] edges;
  logic [15:0]      rising;

  assign update  = in_valid_q && out_advance;
  assign running = !held_q && plugged_q;
  assign rising  = buttons_q & ~btn_hist_q;

  // Gate edge detection; the clock level is only sampled while running
  always_comb begin
    gate_hist_d          = '0;
    gate_hist_d[GateClk] = running ? clk_lvl_q : gate_hist_q[GateClk];
    gate_hist_d[GateRev] = rev_lvl_q;
    gate_hist_d[GateRnd] = rnd_lvl_q;
    gate_hist_d[GateHold] = hold_lvl_q;
    gate_hist_d[GateRst] = rst_lvl_q;
    edges = gate_hist_d & ~gate_hist_q;
  end

  // Mode and position update, in the order clock, reverse, random, hold, reset, buttons
  always_comb begin
    cur_d      = cur_q;
    count_d    = count_q;
    home_d     = home_q;
    held_d     = held_q;
    random_d   = random_q;
    reversed_d = reversed_q;
    hopping_d  = hopping_q;

    if (edges[GateClk]) begin
      count_d = reversed_q ? wrap_dec(count_q) : wrap_add(count_q, 4'd1);
      if (random_q) begin
        if (hopping_q) begin
          cur_d = wrap_add(cur_q, hop_q);
        end else begin
          cur_d = walk_up_q ? wrap_add(cur_q, 4'd1) : wrap_dec(cur_q);
        end
      end else begin
        cur_d = count_d;
      end
    end
    if (edges[GateRev]) begin
      if (random_q) begin
        hopping_d = !hopping_q;
      end else begin
        reversed_d = !reversed_q;
      end
    end
    if (edges[GateRnd]) begin
      random_d = !random_q;
    end
    if (edges[GateHold]) begin
      held_d = !held_q;
    end
    if (edges[GateRst]) begin
      count_d = home_q;
      cur_d   = home_q;
    end
    // highest rising button wins
    for (int i = 0; i < NumBtn; i++) begin
      if (rising[i]) begin
        home_d = IdxW'(i);
        if (!running) begin
          cur_d = IdxW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      count_q     <= '0;
      home_q      <= '0;
      held_q      <= 1'b0;
      random_q    <= 1'b0;
      reversed_q  <= 1'b0;
      hopping_q   <= 1'b0;
      gate_hist_q <= '0;
      btn_hist_q  <= '0;
    end else if (update) begin
      cur_q       <= cur_d;
      count_q     <= count_d;
      home_q      <= home_d;
      held_q      <= held_d;
      random_q    <= random_d;
      reversed_q  <= reversed_d;
      hopping_q   <= hopping_d;
      gate_hist_q <= gate_hist_d;
      btn_hist_q  <= buttons_q;
    end
  end

  // ---------------- result computation ----------------
  logic signed [ValW-1:0] scaled;
  lamps_t                 lamps_d, lamps_q;
  logic [IdxW+3:0]        cur_ext, home_ext;

  ssrm_scale u_scale (
    .sample_i (sample_q),
    .scale_i  (scale_q),
    .offset_i (offset_q),
    .result_o (scaled)
  );

  always_comb begin
    if (held_d) begin
      lamps_d = '{reverse: 1'b1, random: 1'b1, forward: 1'b1};
    end else if (random_d) begin
      lamps_d = '{reverse: !hopping_d, random: hopping_d, forward: !hopping_d};
    end else begin
      lamps_d = '{reverse: reversed_d, random: 1'b0, forward: !reversed_d};
    end
  end

  assign cur_ext  = {4'b0000, cur_d};
  assign home_ext = {4'b0000, home_d};

  // ---------------- result register ----------------
  logic                   out_valid_q;
  logic [3:0]             position_q, reset_position_q;
  logic signed [ValW-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      position_q       <= cur_ext[3:0];
      reset_position_q <= home_ext[3:0];
      out_value_q      <= scaled;
      lamps_q          <= lamps_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign position_o       = position_q;
  assign reset_position_o = reset_position_q;
  assign out_value_o      = out_value_q;
  assign reverse_lamp_o   = lamps_q.reverse;
  assign random_lamp_o    = lamps_q.random;
  assign forward_lamp_o   = lamps_q.forward;

`ifndef SYNTHESIS
  // input side only stalls behind a blocked result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // positions always stay inside the step range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_q) < STEPS) && (32'(count_q) < STEPS) && (32'(home_q) < STEPS))
    else $error("step position out of range");

  // at least one lamp is lit on every result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reverse_lamp_o || random_lamp_o || forward_lamp_o))
    else $error("no lamp lit");

  // every sequencer state update brings a word into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    update |=> out_valid_o)
    else $error("state updated without a result word");
`endif

endmodule
